FILE: rtl/tlt_pkg.sv
// Package for the timeout lease table: request and response beat types,
// operation and status codes, and fixed widths.
// No dependencies.
package tlt_pkg;

	localparam int KEY_WORD_W = 64;
	localparam int KEY_W      = 8 * KEY_WORD_W;
	localparam int STAMP_W    = 32;
	localparam int COUNT_W    = 7;

	localparam logic [STAMP_W-1:0] EXPIRY_RESET = 32'd3600;

	// Operation selector codes.
	localparam logic [2:0] FN_RECORD = 3'd0;
	localparam logic [2:0] FN_SWEEP  = 3'd1;
	localparam logic [2:0] FN_QUERY  = 3'd2;
	localparam logic [2:0] FN_CLEAR  = 3'd3;
	localparam logic [2:0] FN_TICK   = 3'd4;

	// Response status codes.
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_NOMATCH = 2'd2;

	typedef struct packed {
		logic [2:0]            func;
		logic [KEY_WORD_W-1:0] first_key_w0;
		logic [KEY_WORD_W-1:0] first_key_w1;
		logic [KEY_WORD_W-1:0] first_key_w2;
		logic [KEY_WORD_W-1:0] first_key_w3;
		logic [KEY_WORD_W-1:0] second_key_w0;
		logic [KEY_WORD_W-1:0] second_key_w1;
		logic [KEY_WORD_W-1:0] second_key_w2;
		logic [KEY_WORD_W-1:0] second_key_w3;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic               expired;
		logic [COUNT_W-1:0] freed_count;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic exec;
		logic scan;
		logic publish;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_scan;
		logic scan_done;
		logic out_free;
	} sts_t;

endpackage

FILE: rtl/timeout_lease_table.sv
// Timeout lease table. Record, tick and unused codes go from the accepted beat via
// the execute state to the response state, which loads the response register and
// raises rsp_valid; sweep, query and clear walk the filled slots one per cycle, a
// query or clear stopping at a match. One request is in work at a time; the next is
// taken the cycle after the response is loaded; loading waits for a stalled response.
// Reset clears valid bits, slot and seconds counters and sets the timeout to
// 3600; key and stamp memories are not cleared.
module timeout_lease_table
	import tlt_pkg::*;
#(
	parameter int ENTRIES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  req_t               req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output rsp_t               rsp,
	input  logic               cfg_we,
	input  logic [STAMP_W-1:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	// Sequencing of each request.
	tlt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Storage, scan and response register.
	tlt_dpath #(
		.ENTRIES (ENTRIES)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule

FILE: rtl/tlt_ctrl.sv
// Controller state machine of the timeout lease table.
// Depends on tlt_pkg for the command and status structs.
module tlt_ctrl
	import tlt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_RESP
	} state_t;

	state_t state_q;

	// The request side is open only while idle.
	assign req_stall = (state_q != S_IDLE);

	// Commands follow directly from the state, req_valid and the datapath status.
	always_comb begin
		cmd         = '0;
		cmd.capture = (state_q == S_IDLE) && req_valid;
		cmd.exec    = (state_q == S_EXEC);
		cmd.scan    = (state_q == S_SCAN);
		cmd.publish = (state_q == S_RESP) && sts.out_free;
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= sts.is_scan ? S_SCAN : S_RESP;
				end
				S_SCAN: begin
					if (sts.scan_done) begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (sts.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/tlt_dpath.sv
// Datapath of the timeout lease table: key and stamp memories, valid bits,
// slot and seconds counters, the scan pipeline and the response register.
// Depends on tlt_pkg.
module tlt_dpath
	import tlt_pkg::*;
#(
	parameter int ENTRIES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  req_t               req,
	input  logic               cfg_we,
	input  logic [STAMP_W-1:0] cfg_data,
	input  logic               rsp_stall,
	output logic               rsp_valid,
	output rsp_t               rsp
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);

	// Storage.
	logic [KEY_W-1:0]   key_mem   [ENTRIES];
	logic [STAMP_W-1:0] stamp_mem [ENTRIES];
	logic [ENTRIES-1:0] valid_q;

	logic [CNT_W-1:0]   used_q;
	logic [STAMP_W-1:0] seconds_q;
	logic [STAMP_W-1:0] expiry_q;

	// Request and scan state.
	req_t               req_q;
	logic [CNT_W-1:0]   ptr_q;
	logic               pend_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic [KEY_W-1:0]   key_s1;
	logic [STAMP_W-1:0] stamp_s1;
	rsp_t               res_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic [KEY_W-1:0] req_key;
	logic             op_sweep;
	logic             op_seek;
	logic             room;
	logic             rec_ok;
	logic             more;
	logic             slot_live;
	logic             exp_now;
	logic             hit;
	logic             kill;
	logic             issue;
	logic [IDX_W-1:0] used_idx;
	logic [IDX_W-1:0] ptr_idx;

	assign req_key = {req_q.second_key_w3, req_q.second_key_w2,
	                  req_q.second_key_w1, req_q.second_key_w0,
	                  req_q.first_key_w3, req_q.first_key_w2,
	                  req_q.first_key_w1, req_q.first_key_w0};

	assign op_sweep = (req_q.func == FN_SWEEP);
	assign op_seek  = (req_q.func == FN_QUERY) || (req_q.func == FN_CLEAR);
	assign room     = (used_q < CNT_W'(ENTRIES));
	assign rec_ok   = cmd.exec && (req_q.func == FN_RECORD) && room;
	assign used_idx = used_q[IDX_W-1:0];
	assign ptr_idx  = ptr_q[IDX_W-1:0];
	assign more     = (ptr_q < used_q);

	// Evaluation of the slot read in the previous cycle.
	assign slot_live = cmd.scan && pend_s1 && valid_q[idx_s1];
	assign exp_now   = (seconds_q - stamp_s1) > expiry_q;
	assign hit       = slot_live && op_seek && (key_s1 == req_key);
	assign kill      = slot_live && op_sweep && exp_now;
	assign issue     = cmd.scan && more && !hit;

	always_comb begin
		sts           = '0;
		sts.is_scan   = op_sweep || op_seek;
		sts.scan_done = cmd.scan && (hit || (!pend_s1 && !more));
		sts.out_free  = !rsp_valid_q || !rsp_stall;
	end

	// Memories: a record writes one row; the scan reads one row a cycle.
	always_ff @(posedge clk) begin
		if (rec_ok) begin
			key_mem[used_idx]   <= req_key;
			stamp_mem[used_idx] <= seconds_q;
		end
		if (issue) begin
			key_s1   <= key_mem[ptr_idx];
			stamp_s1 <= stamp_mem[ptr_idx];
			idx_s1   <= ptr_idx;
		end
	end

	// Request capture and result accumulation.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req;
		end
		if (cmd.exec) begin
			res_q.expired     <= 1'b0;
			res_q.freed_count <= '0;
			if ((req_q.func == FN_RECORD) && !room) begin
				res_q.status <= ST_FULL;
			end else if (op_seek) begin
				res_q.status <= ST_NOMATCH;
			end else begin
				res_q.status <= ST_OK;
			end
		end
		if (kill) begin
			res_q.freed_count <= res_q.freed_count + 1'b1;
		end
		if (hit) begin
			res_q.status  <= ST_OK;
			res_q.expired <= (req_q.func == FN_QUERY) && exp_now;
		end
		if (cmd.publish) begin
			rsp_q <= res_q;
		end
	end

	// Control state: counters, valid bits, scan pointer, response valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			used_q      <= '0;
			seconds_q   <= '0;
			expiry_q    <= EXPIRY_RESET;
			ptr_q       <= '0;
			pend_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				expiry_q <= cfg_data;
			end
			if (cmd.exec && (req_q.func == FN_TICK)) begin
				seconds_q <= seconds_q + 1'b1;
			end
			if (rec_ok) begin
				valid_q[used_idx] <= 1'b1;
				used_q            <= used_q + 1'b1;
			end
			if (kill || (hit && (req_q.func == FN_CLEAR))) begin
				valid_q[idx_s1] <= 1'b0;
			end
			if (cmd.exec) begin
				ptr_q   <= '0;
				pend_s1 <= 1'b0;
			end else begin
				pend_s1 <= issue;
				if (issue) begin
					ptr_q <= ptr_q + 1'b1;
				end
			end
			if (cmd.publish) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: rtl/tlt_checker.sv
// Port-level checks for the timeout lease table, bound to the top level.
// Depends on tlt_pkg and timeout_lease_table.
module tlt_checker
	import tlt_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	// A waiting response beat holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response beat changed while stalled");

	// After accepting a request the block is busy.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request side open right after a beat");

	// Failed requests carry no count and no expiry flag.
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != ST_OK) |-> !rsp.expired && (rsp.freed_count == '0))
		else $error("failed response carries data");

	// The expiry flag and a sweep count never come together.
	a_exp_nocount: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.expired |-> (rsp.freed_count == '0))
		else $error("expired flag with nonzero count");

endmodule

bind timeout_lease_table tlt_checker u_tlt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
